### rtl/core/base32_stream_encoder_unit_macros.svh
// Assertion macros shared by the Base32 stream encoder RTL
`ifndef BASE32_STREAM_ENCODER_UNIT_MACROS_SVH
`define BASE32_STREAM_ENCODER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define B32_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define B32_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/b32enc_pkg.sv
// Package: item types, group type, queue status and alphabet lookup
package b32enc_pkg;

    localparam int unsigned GroupBytes   = 5;
    localparam int unsigned CharsPerGrp  = 8;
    localparam int unsigned GroupWidth   = 8 * GroupBytes;
    localparam int unsigned HeldWidth    = 8 * (GroupBytes - 1);
    localparam int unsigned QueueDepth   = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic [GroupWidth-1:0] bits;
        logic                  final_group;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] alphabet_char(input logic [4:0] idx);
        logic [6:0] code;
        if (idx < 5'd26)
            code = 7'h41 + {2'b00, idx};
        else
            code = 7'h32 + {2'b00, idx - 5'd26};
        return code;
    endfunction

endpackage

### rtl/core/b32enc_front.sv
// Front end: collect bytes into groups, pad the final group, push to queue
`include "base32_stream_encoder_unit_macros.svh"

module b32enc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  b32enc_pkg::byte_item_t  byte_item,
    input  b32enc_pkg::q_status_t   q_status,
    output logic                    push,
    output b32enc_pkg::group_t      push_group
);

    logic [b32enc_pkg::HeldWidth-1:0] group_bytes_reg, group_bytes_next;
    logic [2:0]                       byte_count_reg, byte_count_next;
    logic [2:0]                       held;
    logic                             accept;
    logic                             complete;
    logic [7:0]                       b;
    logic [b32enc_pkg::HeldWidth-1:0] g;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;
    assign held       = (byte_count_reg > 3'd4) ? 3'd4 : byte_count_reg;
    assign complete   = (held == 3'd4) || byte_item.end_of_message;
    assign push       = accept && complete;
    assign b          = byte_item.data_byte;
    assign g          = group_bytes_reg;

    always_comb
    begin
        push_group.final_group = byte_item.end_of_message;
        unique case (held)
            3'd0:    push_group.bits = {b, {4{8'h34}}};
            3'd1:    push_group.bits = {g[7:0], b, {3{8'h33}}};
            3'd2:    push_group.bits = {g[15:0], b, {2{8'h32}}};
            3'd3:    push_group.bits = {g[23:0], b, 8'h31};
            default: push_group.bits = {g, b};
        endcase
    end

    always_comb
    begin
        group_bytes_next = group_bytes_reg;
        byte_count_next  = byte_count_reg;
        if (accept)
        begin
            if (complete)
            begin
                group_bytes_next = '0;
                byte_count_next  = '0;
            end
            else
            begin
                group_bytes_next = {g[b32enc_pkg::HeldWidth-9:0], b};
                byte_count_next  = held + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bytes_reg <= '0;
            byte_count_reg  <= '0;
        end
        else
        begin
            group_bytes_reg <= group_bytes_next;
            byte_count_reg  <= byte_count_next;
        end
    end

    `B32_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, byte_count_reg <= 3'd4,
                    "byte count above four")
    `B32_ASSERT_NXT(a_clear_after_push, clk, rst_n, push,
                    byte_count_reg == 3'd0 && group_bytes_reg == '0,
                    "group not cleared after push")

endmodule

### rtl/core/b32enc_queue.sv
// Short group queue between front end and character sequencer
`include "base32_stream_encoder_unit_macros.svh"

module b32enc_queue #(
    parameter int unsigned Depth = b32enc_pkg::QueueDepth
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b32enc_pkg::group_t    push_group,
    input  logic                  pop,
    output b32enc_pkg::group_t    head_group,
    output b32enc_pkg::q_status_t q_status
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    b32enc_pkg::group_t slot_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    assign q_status.full  = (count_reg == CntW'(Depth));
    assign q_status.empty = (count_reg == '0);
    assign head_group     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B32_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_status.full,
                    "push into full queue")
    `B32_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !q_status.empty,
                    "pop from empty queue")

endmodule

### rtl/core/b32enc_back.sv
// Back end: shift each group out as eight characters through an output register
`include "base32_stream_encoder_unit_macros.svh"

module b32enc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b32enc_pkg::q_status_t  q_status,
    input  b32enc_pkg::group_t     head_group,
    output logic                   pop,
    output logic                   char_valid,
    input  logic                   char_ready,
    output b32enc_pkg::char_item_t char_item
);

    logic [b32enc_pkg::GroupWidth-1:0] shift_reg, shift_next;
    logic                              final_reg, final_next;
    logic [2:0]                        idx_reg, idx_next;
    logic                              busy_reg, busy_next;
    logic                              out_valid_reg, out_valid_next;
    b32enc_pkg::char_item_t            out_item_reg, out_item_next;
    logic                              advance;
    logic                              last_of_group;

    assign advance       = busy_reg && (!out_valid_reg || char_ready);
    assign last_of_group = (idx_reg == 3'(b32enc_pkg::CharsPerGrp - 1));
    assign pop           = !q_status.empty && (!busy_reg || (advance && last_of_group));
    assign char_valid    = out_valid_reg;
    assign char_item     = out_item_reg;

    always_comb
    begin
        shift_next     = shift_reg;
        final_next     = final_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_valid_reg && char_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next          = 1'b1;
            out_item_next.char_code =
                b32enc_pkg::alphabet_char(shift_reg[b32enc_pkg::GroupWidth-1 -: 5]);
            out_item_next.last_char = final_reg && last_of_group;
            shift_next              = {shift_reg[b32enc_pkg::GroupWidth-6:0], 5'b0};
            idx_next                = idx_reg + 3'd1;
            if (last_of_group)
                busy_next = 1'b0;
        end
        if (pop)
        begin
            shift_next = head_group.bits;
            final_next = head_group.final_group;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        final_reg    <= final_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `B32_ASSERT_IMP(a_idle_index, clk, rst_n, !busy_reg, idx_reg == 3'd0,
                    "character index moved while idle")
    `B32_ASSERT_NXT(a_last_closes_group, clk, rst_n, advance && last_of_group && !pop,
                    !busy_reg, "sequencer still busy after eighth character")

endmodule

### rtl/core/base32_stream_encoder_unit.sv
// Top level: Base32 stream encoder, front end, group queue and character sequencer
//
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item) takes one message byte per
//   item, with end_of_message set on the final byte of the message.
//   char channel (char_valid/char_ready/char_item) gives one Base32 character
//   per item; last_char marks the eighth character of the message's final group.
//   Every five bytes, or the final byte of a short group, yield eight characters;
//   a short final group is filled with ASCII digit pad bytes before encoding.
// Path: the byte that completes a group is written with it into a queue slot;
//   the group then loads the shift register, and its first character the output register.
// Throughput: one character per cycle while char_ready is high, set by the single
//   character output register; the next group loads as the last one's eighth character leaves.
// Reset: empties the group buffer, the queue (QueueDepth entries, two by default) and the output register.
// Stall: when char_ready is low the sequencer holds; the queue still accepts
//   up to QueueDepth (by default two) finished groups before byte_ready drops.
module base32_stream_encoder_unit #(
    parameter int unsigned QueueDepth = b32enc_pkg::QueueDepth
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  b32enc_pkg::byte_item_t byte_item,
    output logic                   char_valid,
    input  logic                   char_ready,
    output b32enc_pkg::char_item_t char_item
);

    b32enc_pkg::q_status_t q_status;
    b32enc_pkg::group_t    push_group;
    b32enc_pkg::group_t    head_group;
    logic                  push;
    logic                  pop;

    b32enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    b32enc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head_group (head_group),
        .q_status   (q_status)
    );

    b32enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_group (head_group),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

endmodule
